[rtl/core/kf_pkg.sv]
// Shared constants and types for the scalar Kalman filter unit.
// No dependencies; every other file in rtl/core imports this package.
package kf_pkg;

	localparam int VAR_WIDTH          = 23;
	localparam int NOISE_WIDTH        = 16;
	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int REG_INDEX_WIDTH    = 3;

	localparam logic [REG_INDEX_WIDTH-1:0] REG_INIT_ESTIMATE = 3'd0;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_INIT_VARIANCE = 3'd1;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE = 3'd2;
	localparam logic [REG_INDEX_WIDTH-1:0] REG_MEAS_NOISE    = 3'd3;

	localparam logic [VAR_WIDTH-1:0]   INIT_VARIANCE_RST = 23'd256;
	localparam logic [NOISE_WIDTH-1:0] PROCESS_NOISE_RST = 16'd1;
	localparam logic [VAR_WIDTH-1:0]   MEAS_NOISE_RST    = 23'd256;

	// Status of a serial arithmetic unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} kf_unit_st_t;

endpackage

[rtl/core/kf_in_if.sv]
// Request channel carrying one measurement sample.
// Depends on kf_pkg for the default sample width.
interface kf_in_if import kf_pkg::*; #(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

[rtl/core/kf_out_if.sv]
// Result channel carrying the filtered estimate and the gain used.
// Depends on kf_pkg for the default widths.
interface kf_out_if import kf_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] estimate;
	logic [GAIN_FRAC_BITS:0]        gain;

	modport source (output valid, output estimate, output gain, input ready);
	modport sink (input valid, input estimate, input gain, output ready);
endinterface

[rtl/core/kf_div.sv]
// Restoring radix-2 divider producing the filter gain, one quotient bit per cycle.
// Depends on kf_pkg for the unit status struct.
module kf_div import kf_pkg::*; #(
	parameter int VW = VAR_WIDTH,
	parameter int FB = GAIN_FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [VW-1:0] num,
	input  logic [VW:0]   den,
	output logic [FB:0]   quot,
	output kf_unit_st_t   st
);
	localparam int              CNT_W = $clog2(FB + 1);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(FB);

	logic [VW+1:0]    rem_q;
	logic [VW:0]      den_q;
	logic [FB:0]      quot_q;
	logic             zero_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic             ge;
	logic [VW+1:0]    rem_sub;
	logic [VW+1:0]    rem_nxt;

	// The numerator never exceeds the denominator, so the quotient is at most
	// one in FB fractional bits and the remainder starts as the numerator.
	always_comb begin
		ge      = rem_q >= {1'b0, den_q};
		rem_sub = rem_q - {1'b0, den_q};
		rem_nxt = ge ? rem_sub : rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {2'b00, num};
			den_q  <= den;
			zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q  <= {rem_nxt[VW:0], 1'b0};
			quot_q <= {quot_q[FB-1:0], ge & ~zero_q};
		end
	end

	assign quot    = quot_q;
	assign st.busy = busy_q;
	assign st.done = done_q;
endmodule

[rtl/core/kf_mul.sv]
// Serial shift-add multiplier: floor(mcand * mplier / 2^(NB-1)), one multiplier bit
// per cycle, LSB first. Depends on kf_pkg for the unit status struct.
module kf_mul import kf_pkg::*; #(
	parameter int MW = SAMPLE_WIDTH_DEF + 1,
	parameter int NB = GAIN_FRAC_BITS_DEF + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [MW-1:0] mcand,
	input  logic [NB-1:0]        mplier,
	output logic signed [MW:0]   prod,
	output kf_unit_st_t          st
);
	localparam int              CNT_W = $clog2(NB);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(NB - 1);

	logic signed [MW:0]   acc_q;
	logic signed [MW-1:0] mc_q;
	logic [NB-1:0]        bits_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic signed [MW:0]   addend;
	logic signed [MW:0]   sum;

	// Halving after every step but the last floors the product by 2^(NB-1);
	// the arithmetic shift keeps that a floor for negative multiplicands.
	always_comb begin
		addend = bits_q[0] ? $signed({mc_q[MW-1], mc_q}) : '0;
		sum    = acc_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q  <= '0;
			mc_q   <= mcand;
			bits_q <= mplier;
		end else if (busy_q) begin
			acc_q  <= (cnt_q == LAST) ? sum : (sum >>> 1);
			bits_q <= bits_q >> 1;
		end
	end

	assign prod    = acc_q;
	assign st.busy = busy_q;
	assign st.done = done_q;
endmodule

[rtl/core/scalar_kalman_filter_unit.sv]
// Scalar Kalman filter, fixed point. Depends on kf_pkg, kf_in_if, kf_out_if,
// kf_div and kf_mul.
//
// Each request on sample_ch carries one signed measurement. The unit adds the
// process noise to the error variance (saturating), divides out the gain
// k = variance*2^GAIN_FRAC_BITS/(variance+measurement_noise), moves the estimate
// by k*(sample-estimate)/2^GAIN_FRAC_BITS and shrinks the variance by (1-k).
// result_ch returns the new estimate and k for every sample, in order.
// Items are handled one at a time. A taken sample passes through ST_PREP,
// ST_DIV (the bit-serial gain divider) and ST_MUL (the two bit-serial
// multipliers, run side by side); the result is registered when ST_MUL
// finishes, and the unit then returns to ST_IDLE to take the next sample.
// The result sits in an output register; a new sample is accepted while it
// waits. If the receiver stalls, a finished item is held until the output
// register frees up, and no further sample is accepted meanwhile.
// Reset loads the register defaults and sets the estimate to 0 and the
// variance to 256. Any register write (wr_en) reloads estimate and variance
// from the initial registers; writes are meant only while the unit is idle.
module scalar_kalman_filter_unit import kf_pkg::*; #(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	localparam int CFG_WIDTH = (SAMPLE_WIDTH > VAR_WIDTH) ? SAMPLE_WIDTH : VAR_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [REG_INDEX_WIDTH-1:0] wr_index,
	input  logic [CFG_WIDTH-1:0]       wr_data,
	kf_in_if.sink                      sample_ch,
	kf_out_if.source                   result_ch
);
	localparam int SW = SAMPLE_WIDTH;
	localparam int FB = GAIN_FRAC_BITS;

	localparam logic [FB:0]                GAIN_ONE  = {1'b1, {FB{1'b0}}};
	localparam logic [VAR_WIDTH-1:0]       VAR_MAX   = '1;
	localparam logic signed [SW+1:0]       EST_MAX_X = {3'b000, {(SW-1){1'b1}}};
	localparam logic signed [SW+1:0]       EST_MIN_X = {3'b111, {(SW-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PREP = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_MUL  = 4'b1000
	} kf_state_t;

	kf_state_t state_q;

	logic signed [SW-1:0]   init_est_q;
	logic [VAR_WIDTH-1:0]   init_var_q;
	logic [NOISE_WIDTH-1:0] q_noise_q;
	logic [VAR_WIDTH-1:0]   r_noise_q;

	logic signed [SW-1:0]   est_q;
	logic [VAR_WIDTH-1:0]   var_q;

	logic signed [SW:0]     diff_q;
	logic [VAR_WIDTH-1:0]   p_q;

	logic                   out_valid_q;
	logic signed [SW-1:0]   out_est_q;
	logic [FB:0]            out_gain_q;

	logic                   accept;
	logic                   commit;
	logic [VAR_WIDTH:0]     p_sum;
	logic [VAR_WIDTH-1:0]   p_sat;
	logic signed [SW:0]     diff_nxt;
	logic [VAR_WIDTH:0]     den;
	logic [FB:0]            gain;
	logic [FB:0]            one_minus_k;
	logic                   div_start;
	logic                   mul_start;
	logic signed [SW+1:0]   prod_x;
	logic signed [VAR_WIDTH+1:0] prod_v;
	logic signed [SW+1:0]   x_sum;
	logic signed [SW-1:0]   x_new;
	logic [VAR_WIDTH-1:0]   var_new;
	logic signed [SW-1:0]   load_est;
	logic [VAR_WIDTH-1:0]   load_var;

	kf_unit_st_t div_st;
	kf_unit_st_t mul_x_st;
	kf_unit_st_t mul_v_st;

	assign accept    = sample_ch.valid && sample_ch.ready;
	assign div_start = (state_q == ST_PREP);
	assign mul_start = (state_q == ST_DIV) && div_st.done;
	assign commit    = (state_q == ST_MUL) && mul_x_st.done
			&& (!out_valid_q || result_ch.ready);

	always_comb begin
		p_sum       = {1'b0, var_q} + (VAR_WIDTH + 1)'(q_noise_q);
		p_sat       = p_sum[VAR_WIDTH] ? VAR_MAX : p_sum[VAR_WIDTH-1:0];
		diff_nxt    = $signed({sample_ch.sample[SW-1], sample_ch.sample})
				- $signed({est_q[SW-1], est_q});
		den         = {1'b0, p_q} + {1'b0, r_noise_q};
		one_minus_k = GAIN_ONE - gain;
		x_sum       = $signed({{2{est_q[SW-1]}}, est_q}) + prod_x;
		if (x_sum > EST_MAX_X) begin
			x_new = EST_MAX_X[SW-1:0];
		end else if (x_sum < EST_MIN_X) begin
			x_new = EST_MIN_X[SW-1:0];
		end else begin
			x_new = x_sum[SW-1:0];
		end
		var_new  = prod_v[VAR_WIDTH-1:0];
		load_est = (wr_index == REG_INIT_ESTIMATE) ? wr_data[SW-1:0] : init_est_q;
		load_var = (wr_index == REG_INIT_VARIANCE) ? wr_data[VAR_WIDTH-1:0] : init_var_q;
	end

	kf_div #(
		.VW(VAR_WIDTH),
		.FB(FB)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (p_q),
		.den   (den),
		.quot  (gain),
		.st    (div_st)
	);

	kf_mul #(
		.MW(SW + 1),
		.NB(FB + 1)
	) u_mul_est (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.mcand (diff_q),
		.mplier(gain),
		.prod  (prod_x),
		.st    (mul_x_st)
	);

	kf_mul #(
		.MW(VAR_WIDTH + 1),
		.NB(FB + 1)
	) u_mul_var (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.mcand ($signed({1'b0, p_q})),
		.mplier(one_minus_k),
		.prod  (prod_v),
		.st    (mul_v_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_st.done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Configuration registers and filter state; a write reloads the state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_est_q <= '0;
			init_var_q <= INIT_VARIANCE_RST;
			q_noise_q  <= PROCESS_NOISE_RST;
			r_noise_q  <= MEAS_NOISE_RST;
			est_q      <= '0;
			var_q      <= INIT_VARIANCE_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_INIT_ESTIMATE: init_est_q <= wr_data[SW-1:0];
				REG_INIT_VARIANCE: init_var_q <= wr_data[VAR_WIDTH-1:0];
				REG_PROCESS_NOISE: q_noise_q  <= wr_data[NOISE_WIDTH-1:0];
				REG_MEAS_NOISE:    r_noise_q  <= wr_data[VAR_WIDTH-1:0];
				default: begin
				end
			endcase
			est_q <= load_est;
			var_q <= load_var;
		end else if (commit) begin
			est_q <= x_new;
			var_q <= var_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= p_sat;
			diff_q <= diff_nxt;
		end
		if (commit) begin
			out_est_q  <= x_new;
			out_gain_q <= gain;
		end
	end

	assign sample_ch.ready    = (state_q == ST_IDLE);
	assign result_ch.valid    = out_valid_q;
	assign result_ch.estimate = out_est_q;
	assign result_ch.gain     = out_gain_q;

`ifndef NO_ASSERTIONS
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> result_ch.gain <= GAIN_ONE)
		else $error("gain above one");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_PREP)
		else $error("accepted sample did not start the update");

	a_ready_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sample_ch.ready |-> !div_st.busy && !mul_x_st.busy && !mul_v_st.busy)
		else $error("ready while an arithmetic unit is busy");

	a_mul_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		mul_x_st.done == mul_v_st.done)
		else $error("multipliers out of step");

	a_div_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start |=> mul_x_st.busy && state_q == ST_MUL)
		else $error("multipliers not started after the division");

	a_var_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> var_new <= p_q)
		else $error("updated variance above predicted variance");
`endif
endmodule
